FILE: hw/rtl/hbse_pkg.sv
// hbse_pkg: constants, types and helper functions of the hit bitmap set engine
// used by hbse_ram users and by hit_bitmap_set_engine_unit; depends on nothing

package hbse_pkg;

	localparam int MAX_WORDS     = 4096;
	localparam int BITS_PER_WORD = 32;
	localparam int STORE_WORDS   = (MAX_WORDS + BITS_PER_WORD - 1) / BITS_PER_WORD;
	localparam int RAM_AW        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int CNT_W         = $clog2(STORE_WORDS + 1);
	localparam int PAD_REM       = MAX_WORDS % BITS_PER_WORD;

	localparam int MODE_W  = 3;
	localparam int WIDX_W  = 16;
	localparam int WADDR_W = 7;
	localparam int TOTAL_W = 13;
	localparam int LIST_W  = 8;
	localparam int EIDX_W  = 12;
	localparam int POP_W   = 6;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [31:0] POP_M1 = 32'h5555_5555;
	localparam logic [31:0] POP_M2 = 32'h3333_3333;
	localparam logic [31:0] POP_M4 = 32'h0F0F_0F0F;
	localparam logic [31:0] POP_H1 = 32'h0101_0101;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 3'd0,
		MODE_ADD    = 3'd1,
		MODE_TEST   = 3'd2,
		MODE_AND    = 3'd3,
		MODE_OR     = 3'd4,
		MODE_INVERT = 3'd5,
		MODE_COUNT  = 3'd6,
		MODE_LIST   = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MOD  = 4'b0010,
		S_LIST = 4'b0100,
		S_WALK = 4'b1000
	} state_t;

	// swar popcount, byte lanes summed instead of the multiply by POP_H1
	function automatic logic [POP_W-1:0] popcount32(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = v - ((v >> 1) & POP_M1);
		b = (a & POP_M2) + ((a >> 2) & POP_M2);
		c = (b + (b >> 4)) & POP_M4;
		c = c & {4{POP_H1[7:0] | 8'hFF}};
		return POP_W'(c[7:0]) + POP_W'(c[15:8]) + POP_W'(c[23:16]) + POP_W'(c[31:24]);
	endfunction

	// padding bits above MAX_WORDS in the last store word stay zero
	function automatic logic [31:0] word_mask(input logic [RAM_AW-1:0] addr);
		logic [31:0] m;
		m = '1;
		if (PAD_REM != 0 && addr == RAM_AW'(STORE_WORDS - 1)) begin
			m = (32'd1 << PAD_REM) - 32'd1;
		end
		return m;
	endfunction

endpackage

FILE: hw/rtl/hbse_ram.sv
// hbse_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependency

module hbse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/hit_bitmap_set_engine_unit.sv
// hit_bitmap_set_engine_unit: bitmap of found indices with hit count and set operations
// depends on hbse_pkg and hbse_ram
// clear, out-of-range items and count with a fresh total answer straight from idle;
// add, test, and, or read their ram word, then answer; invert and stale count walk
// every ram word (one ram word per cycle through the popcount/invert datapath);
// list word gives one result per listed entry, one empty result if none is listed.
// busy stays high until the item's last result.
// reset clears all word valid bits (bitmap reads as zero), count, stale flag and
// list_number at once; no clearing pass. results are strobed and cannot be stalled.

module hit_bitmap_set_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hbse_pkg::MODE_W-1:0]   mode,
	input  logic [hbse_pkg::WIDX_W-1:0]   word_index,
	input  logic [hbse_pkg::WADDR_W-1:0]  word_address,
	input  logic [31:0]                   other_word,
	input  logic [hbse_pkg::TOTAL_W-1:0]  max_entries,
	input  logic                          first_of_pass,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hbse_pkg::LIST_W-1:0]   cfg_data,
	output logic                          result_valid,
	output logic                          status,
	output logic                          present,
	output logic [hbse_pkg::TOTAL_W-1:0]  hit_count,
	output logic [hbse_pkg::LIST_W-1:0]   entry_list,
	output logic [hbse_pkg::EIDX_W-1:0]   entry_index,
	output logic                          entry_valid,
	output logic                          last
);

	import hbse_pkg::*;

	state_t                 state_q;
	mode_t                  mode_q;
	logic [4:0]             bit_q;
	logic [RAM_AW-1:0]      addr_q;
	logic [WADDR_W-1:0]     waddr_q;
	logic [31:0]            other_q;
	logic [TOTAL_W-1:0]     maxe_q;
	logic [LIST_W-1:0]      list_number_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   stale_q;
	logic [TOTAL_W-1:0]     listed_q;
	logic [STORE_WORDS-1:0] valid_q;
	logic [31:0]            scan_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TOTAL_W-1:0]     sum_q;
	logic                   rd_s1;
	logic [RAM_AW-1:0]      addr_s1;
	logic                   vld_s1;

	logic              accept;
	mode_t             mode_in;
	logic              widx_bad;
	logic              addr_bad;
	logic [RAM_AW-1:0] raddr_c;
	logic [31:0]       rdata;
	logic [31:0]       word_c;
	logic              walk_rd;
	logic              walk_end;
	logic              we_c;
	logic [RAM_AW-1:0] waddr_c;
	logic [31:0]       wdata_c;
	logic [TOTAL_W:0]  sum_wide;
	logic [TOTAL_W-1:0] sum_next;
	logic [4:0]        pos_c;
	logic [31:0]       rest_c;
	logic              list_end;

	logic                emit;
	logic                e_status;
	logic                e_present;
	logic [TOTAL_W-1:0]  e_count;
	logic                e_entry;
	logic                e_last;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign mode_in   = mode_t'(mode);
	assign widx_bad  = {16'd0, word_index} >= 32'(MAX_WORDS);
	assign addr_bad  = {25'd0, word_address} >= 32'(STORE_WORDS);

	assign walk_rd  = (state_q == S_WALK) && (cnt_q < CNT_W'(STORE_WORDS));
	assign walk_end = (state_q == S_WALK) && rd_s1 && (addr_s1 == RAM_AW'(STORE_WORDS - 1));
	assign word_c   = vld_s1 ? rdata : '0;

	always_comb begin
		raddr_c = cnt_q[RAM_AW-1:0];
		if (state_q == S_IDLE) begin
			if (mode_in == MODE_ADD || mode_in == MODE_TEST) begin
				raddr_c = RAM_AW'(word_index >> 5);
			end else begin
				raddr_c = RAM_AW'(word_address);
			end
		end
	end

	hbse_ram #(
		.WIDTH (BITS_PER_WORD),
		.DEPTH (STORE_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (raddr_c),
		.rdata (rdata)
	);

	// count walk datapath: popcount accumulate with saturation
	assign sum_wide = {1'b0, sum_q} + (TOTAL_W + 1)'(popcount32(word_c));
	assign sum_next = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

	// lowest set bit of the word being listed
	always_comb begin
		pos_c = '0;
		for (int i = 31; i >= 0; i--) begin
			if (scan_q[i]) begin
				pos_c = 5'(i);
			end
		end
	end
	assign rest_c   = scan_q & (scan_q - 32'd1);
	assign list_end = (rest_c == '0) ||
		(({1'b0, listed_q} + (TOTAL_W + 1)'(1)) >= {1'b0, maxe_q});

	// ram write and result selection
	always_comb begin
		we_c      = 1'b0;
		waddr_c   = addr_q;
		wdata_c   = word_c;
		emit      = 1'b0;
		e_status  = 1'b0;
		e_present = 1'b0;
		e_count   = '0;
		e_entry   = 1'b0;
		e_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode_in)
						MODE_CLEAR: emit = 1'b1;
						MODE_ADD, MODE_TEST: begin
							emit     = widx_bad;
							e_status = widx_bad;
						end
						MODE_AND, MODE_OR, MODE_LIST: begin
							emit     = addr_bad;
							e_status = addr_bad;
						end
						MODE_COUNT: begin
							emit    = !stale_q;
							e_count = total_q;
						end
						default: ;
					endcase
				end
			end
			S_MOD: begin
				case (mode_q)
					MODE_ADD: begin
						we_c    = 1'b1;
						wdata_c = word_c | (32'd1 << bit_q);
						emit    = 1'b1;
					end
					MODE_TEST: begin
						emit      = 1'b1;
						e_present = word_c[bit_q];
					end
					MODE_AND: begin
						we_c    = 1'b1;
						wdata_c = word_c & other_q;
						emit    = 1'b1;
					end
					MODE_OR: begin
						we_c    = 1'b1;
						wdata_c = word_c | (other_q & word_mask(addr_q));
						emit    = 1'b1;
					end
					default: ;
				endcase
			end
			S_LIST: begin
				emit = 1'b1;
				if (scan_q != '0 && listed_q < maxe_q) begin
					e_entry = 1'b1;
					e_last  = list_end;
				end
			end
			S_WALK: begin
				waddr_c = addr_s1;
				if (rd_s1 && mode_q == MODE_INVERT) begin
					we_c    = 1'b1;
					wdata_c = ~word_c & word_mask(addr_s1);
				end
				if (walk_end) begin
					emit = 1'b1;
					if (mode_q == MODE_COUNT) begin
						e_count = sum_next;
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			total_q       <= '0;
			stale_q       <= 1'b0;
			listed_q      <= '0;
			valid_q       <= '0;
			list_number_q <= '0;
			cnt_q         <= '0;
			rd_s1         <= 1'b0;
		end else begin
			rd_s1 <= walk_rd;
			if (cfg_valid && cfg_ready) begin
				list_number_q <= cfg_data;
			end
			if (we_c) begin
				valid_q[waddr_c] <= 1'b1;
			end
			if (walk_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (mode_in)
							MODE_CLEAR: begin
								valid_q <= '0;
								total_q <= '0;
								stale_q <= 1'b0;
							end
							MODE_ADD, MODE_TEST: begin
								if (!widx_bad) begin
									state_q <= S_MOD;
								end
							end
							MODE_AND, MODE_OR: begin
								if (!addr_bad) begin
									state_q <= S_MOD;
								end
							end
							MODE_LIST: begin
								if (first_of_pass) begin
									listed_q <= '0;
								end
								if (!addr_bad) begin
									state_q <= S_MOD;
								end
							end
							MODE_INVERT: state_q <= S_WALK;
							MODE_COUNT: begin
								if (stale_q) begin
									state_q <= S_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				S_MOD: begin
					if (mode_q == MODE_LIST) begin
						state_q <= S_LIST;
					end else begin
						state_q <= S_IDLE;
					end
					case (mode_q)
						MODE_ADD: begin
							if (!word_c[bit_q] && total_q != TOTAL_MAX) begin
								total_q <= total_q + TOTAL_W'(1);
							end
						end
						MODE_AND, MODE_OR: stale_q <= 1'b1;
						default: ;
					endcase
				end
				S_LIST: begin
					if (e_entry) begin
						listed_q <= listed_q + TOTAL_W'(1);
					end
					if (e_last) begin
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (walk_end) begin
						state_q <= S_IDLE;
						if (mode_q == MODE_COUNT) begin
							total_q <= sum_next;
							stale_q <= 1'b0;
						end else begin
							stale_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item fields and datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= raddr_c;
		vld_s1  <= valid_q[raddr_c];
		if (accept) begin
			mode_q  <= mode_in;
			bit_q   <= word_index[4:0];
			addr_q  <= raddr_c;
			waddr_q <= word_address;
			other_q <= other_word;
			maxe_q  <= max_entries;
			sum_q   <= '0;
		end
		if (state_q == S_WALK && rd_s1) begin
			sum_q <= sum_next;
		end
		if (state_q == S_MOD) begin
			scan_q <= word_c;
		end else if (state_q == S_LIST) begin
			scan_q <= rest_c;
		end
	end

	// result register, one beat per strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status      <= e_status;
			present     <= e_present;
			hit_count   <= e_count;
			entry_list  <= e_entry ? list_number_q : '0;
			entry_index <= e_entry ? EIDX_W'({waddr_q, pos_c}) : '0;
			entry_valid <= e_entry;
			last        <= e_last;
		end
	end

	a_entry_ok : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && entry_valid |-> !status)
		else $error("listed entry carries error status");

	a_not_last_is_entry : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> entry_valid)
		else $error("non-final result without an entry");

	a_clear_one_beat : assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_in == MODE_CLEAR |=> result_valid && last && !busy)
		else $error("clear did not answer in one cycle");

	a_write_when_working : assert property (@(posedge clk) disable iff (!arst_n)
		we_c |-> state_q == S_MOD || state_q == S_WALK)
		else $error("ram write outside modify or walk");

	a_idle_after_last : assert property (@(posedge clk) disable iff (!arst_n)
		emit && e_last |=> !busy)
		else $error("sequencer busy after final result");

endmodule
